@@ src/fcvf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the confidence value fusion block: constants, sequencer states,
// request structs and the arctangent table. No dependencies.
package fcvf_pkg;

    localparam int MAP_SIDE = 128;
    localparam int CELLS    = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ITER     = 16;
    localparam int XY_W     = 26;
    localparam int Z_W      = 32;
    localparam int NUM_W    = 34;
    localparam int DEN_W    = 17;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam logic [14:0] FOV_RESET = 15'd14382;
    localparam logic signed [XY_W-1:0] COS_GAIN = XY_W'(39797);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROUTE,
        ST_W_VEC,
        ST_BEAR,
        ST_DIVP_GO,
        ST_W_DIVP,
        ST_COS_GO,
        ST_W_COS,
        ST_SQ,
        ST_CONF,
        ST_MUL,
        ST_DIVC_GO,
        ST_W_DIVC,
        ST_DIVV_GO,
        ST_W_DIVV,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic                   vect;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
    } cordic_req_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    function automatic logic [Z_W-1:0] atan_angle(input logic [3:0] i);
        logic [Z_W-1:0] a;
        unique case (i)
            4'd0:  a = 32'h20000000;
            4'd1:  a = 32'h12E4051E;
            4'd2:  a = 32'h09FB385B;
            4'd3:  a = 32'h051111D4;
            4'd4:  a = 32'h028B0D43;
            4'd5:  a = 32'h0145D7E1;
            4'd6:  a = 32'h00A2F61E;
            4'd7:  a = 32'h00517C55;
            4'd8:  a = 32'h0028BE53;
            4'd9:  a = 32'h00145F2F;
            4'd10: a = 32'h000A2F98;
            4'd11: a = 32'h000517CC;
            4'd12: a = 32'h00028BE6;
            4'd13: a = 32'h000145F3;
            4'd14: a = 32'h0000A2F9;
            default: a = 32'h0000517C;
        endcase
        return a;
    endfunction

endpackage

@@ src/fcvf_cordic.sv @@
`timescale 1ns / 1ps
// Shared CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on fcvf_pkg.
module fcvf_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcvf_pkg::cordic_req_t         req,
    output logic                          done,
    output logic signed [fcvf_pkg::XY_W-1:0] x_out,
    output logic [fcvf_pkg::Z_W-1:0]      z_out
);
    import fcvf_pkg::*;

    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next, xsh, ysh;
    logic [Z_W-1:0]         z_reg, z_next;
    logic                   vect_reg;
    logic [3:0]             cnt_reg;
    logic                   busy_reg, done_reg;
    logic                   sigma;

    always_comb
    begin
        xsh   = x_reg >>> cnt_reg;
        ysh   = y_reg >>> cnt_reg;
        sigma = vect_reg ? !(y_reg > 0) : !z_reg[Z_W-1];
        if (sigma)
        begin
            x_next = x_reg - ysh;
            y_next = y_reg + xsh;
            z_next = z_reg - atan_angle(cnt_reg);
        end
        else
        begin
            x_next = x_reg + ysh;
            y_next = y_reg - xsh;
            z_next = z_reg + atan_angle(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'(ITER - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(ITER - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.x;
            y_reg    <= req.y;
            z_reg    <= req.z;
            vect_reg <= req.vect;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign z_out = z_reg;

endmodule

@@ src/fcvf_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on fcvf_pkg.
module fcvf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcvf_pkg::div_req_t          req,
    output logic                        done,
    output logic [fcvf_pkg::NUM_W-1:0]  quo
);
    import fcvf_pkg::*;

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [DEN_W:0]   trial, diff;
    logic             fits;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ src/fov_confidence_value_fusion_top.sv @@
`timescale 1ns / 1ps
// Top level of the confidence value fusion block: sequencer, map memory, multiplier.
// Depends on fcvf_pkg, fcvf_cordic and fcvf_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one cell transaction: action, cell
//   indices, sensor pose and match score. Output channel (out_valid / out_stall)
//   returns exactly one transaction per input: the stored confidence and value
//   after the item and a fused flag.
//   cfg_we / cfg_wdata write the field of view; write it only while idle.
//   After reset the block sweeps the map memory to zero, one cell per cycle, with
//   in_stall high. Configuration writes are taken meanwhile. A read action passes
//   the read, route and done states. A fuse action runs one shared CORDIC unit
//   twice (16 steps each), the serial divider three times (34 steps each) and one
//   multiplier five times; a zero squared cosine ends it after the squaring step.
//   One item is in flight at a time; in_stall stays high until its result
//   is placed in the output register. A stalled result holds in the output
//   register while the next item is already accepted and computed; that item
//   waits in its final state until the register frees up.
module fov_confidence_value_fusion_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [6:0]  cell_col,
    input  logic [6:0]  cell_row,
    input  logic [12:0] sensor_x,
    input  logic [12:0] sensor_y,
    input  logic [15:0] sensor_heading,
    input  logic [15:0] match_score,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] cell_confidence,
    output logic [15:0] cell_value,
    output logic        fused
);
    import fcvf_pkg::*;

    state_t state_reg, state_next;

    logic [14:0]       fov_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // latched transaction
    logic        action_reg;
    logic [6:0]  col_reg, row_reg;
    logic [12:0] sx_reg, sy_reg;
    logic [15:0] yaw_reg, score_reg;

    // map memory: confidence in the upper half, value in the lower half
    logic [31:0] map_mem [CELLS];
    logic [31:0] rd_reg;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_addr, cell_addr;
    logic [31:0] mem_wd;

    logic        range_ok;
    logic signed [14:0] dx, dy;
    logic signed [XY_W-1:0] vx, vy;
    logic        zero_vec, zero_reg;

    cordic_req_t cordic_req;
    logic        cordic_done;
    logic signed [XY_W-1:0] cordic_x;
    logic [Z_W-1:0] cordic_z;

    div_req_t    div_req;
    logic        div_done;
    logic [NUM_W-1:0] div_quo;

    logic [15:0] bear, rel16, mag_reg, mag_next;
    logic [16:0] xc;
    logic [16:0] mul_a, mul_b;
    logic [33:0] prod_reg;
    logic [33:0] acc1_reg, acc2_reg;
    logic [2:0]  mul_cnt_reg;
    logic [16:0] sq_round;
    logic [15:0] c_reg, c_next;
    logic [15:0] l_conf, l_val;
    logic [16:0] den;
    logic [15:0] quo_sat;

    logic [15:0] res_conf_reg, res_val_reg;
    logic        res_fused_reg;
    logic        out_load, out_valid_reg;
    logic [15:0] out_conf_reg, out_val_reg;
    logic        out_fused_reg;

    fcvf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .done  (cordic_done),
        .x_out (cordic_x),
        .z_out (cordic_z)
    );

    fcvf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // address and bearing vector setup
    always_comb
    begin
        range_ok  = (int'(col_reg) < MAP_SIDE) && (int'(row_reg) < MAP_SIDE);
        cell_addr = ADDR_W'(int'(row_reg) * MAP_SIDE + int'(col_reg));
        dx = $signed({2'b00, col_reg, 6'd32}) - $signed({2'b00, sx_reg});
        dy = $signed({2'b00, row_reg, 6'd32}) - $signed({2'b00, sy_reg});
        zero_vec = (dx == 15'sd0) && (dy == 15'sd0);
        vx = {{(XY_W - 23){dx[14]}}, dx, 8'b0};
        vy = {{(XY_W - 23){dy[14]}}, dy, 8'b0};
        l_conf = rd_reg[31:16];
        l_val  = rd_reg[15:0];
        den    = {1'b0, c_reg} + {1'b0, l_conf};
        quo_sat = (div_quo[NUM_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
    end

    // relative angle magnitude from the bearing
    always_comb
    begin
        bear     = zero_reg ? 16'd0 : 16'((cordic_z + 32'h0000_8000) >> 16);
        rel16    = bear - yaw_reg;
        mag_next = rel16[15] ? 16'(-rel16) : rel16;
    end

    // clamp the cosine and select the shared multiplier's operands: its square, then the fusion products
    always_comb
    begin
        if (cordic_x < 0)
            xc = 17'd0;
        else if (cordic_x > XY_W'(65536))
            xc = 17'd65536;
        else
            xc = cordic_x[16:0];
        sq_round = 17'((prod_reg + 34'd32768) >> 16);
        c_next   = sq_round[16] ? 16'hFFFF : sq_round[15:0];
        mul_a = 17'd0;
        mul_b = 17'd0;
        if (state_reg == ST_SQ)
        begin
            mul_a = xc;
            mul_b = xc;
        end
        else
        begin
            unique case (mul_cnt_reg)
                3'd0:
                begin
                    mul_a = {1'b0, c_reg};
                    mul_b = {1'b0, c_reg};
                end
                3'd1:
                begin
                    mul_a = {1'b0, l_conf};
                    mul_b = {1'b0, l_conf};
                end
                3'd2:
                begin
                    mul_a = {1'b0, c_reg};
                    mul_b = {1'b0, score_reg};
                end
                3'd3:
                begin
                    mul_a = {1'b0, l_conf};
                    mul_b = {1'b0, l_val};
                end
                default:
                begin
                    mul_a = 17'd0;
                    mul_b = 17'd0;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_ROUTE;
            ST_ROUTE:
                if (!range_ok || action_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_W_VEC;
            ST_W_VEC:
                if (cordic_done)
                    state_next = ST_BEAR;
            ST_BEAR:
                state_next = ST_DIVP_GO;
            ST_DIVP_GO:
                state_next = ST_W_DIVP;
            ST_W_DIVP:
                if (div_done)
                    state_next = ST_COS_GO;
            ST_COS_GO:
                state_next = ST_W_COS;
            ST_W_COS:
                if (cordic_done)
                    state_next = ST_SQ;
            ST_SQ:
                state_next = ST_CONF;
            ST_CONF:
                if (c_next == 16'd0)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            ST_MUL:
                if (mul_cnt_reg == 3'd4)
                    state_next = ST_DIVC_GO;
            ST_DIVC_GO:
                state_next = ST_W_DIVC;
            ST_W_DIVC:
                if (div_done)
                    state_next = ST_DIVV_GO;
            ST_DIVV_GO:
                state_next = ST_W_DIVV;
            ST_W_DIVV:
                if (div_done)
                    state_next = ST_WRITE;
            ST_WRITE:
                state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        mem_we     = 1'b0;
        mem_addr   = cell_addr;
        mem_wd     = {res_conf_reg, res_val_reg};
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
        cordic_req = '0;
        div_req    = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                mem_wd   = 32'd0;
            end
            ST_ROUTE:
            begin
                cordic_req.start = range_ok && !action_reg;
                cordic_req.vect  = 1'b1;
                cordic_req.x     = vx[XY_W-1] ? -vx : vx;
                cordic_req.y     = vx[XY_W-1] ? -vy : vy;
                cordic_req.z     = vx[XY_W-1] ? 32'h8000_0000 : 32'd0;
            end
            ST_DIVP_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'({mag_reg, 16'd0} + {17'd0, fov_reg});
                div_req.den   = DEN_W'({fov_reg, 1'b0});
            end
            ST_COS_GO:
            begin
                // fold the phase into a quarter turn by reading it as signed
                cordic_req.start = 1'b1;
                cordic_req.vect  = 1'b0;
                cordic_req.x     = COS_GAIN;
                cordic_req.y     = '0;
                cordic_req.z     = {div_quo[14], div_quo[14:0], 16'd0};
            end
            ST_DIVC_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = acc1_reg + NUM_W'(den >> 1);
                div_req.den   = den;
            end
            ST_DIVV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = acc2_reg + NUM_W'(den >> 1);
                div_req.den   = den;
            end
            ST_WRITE:
                mem_we = 1'b1;
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fov_reg       <= FOV_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            // a zero field of view behaves as one unit
            if (cfg_we)
                fov_reg <= (cfg_wdata == 15'd0) ? 15'd1 : cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_addr] <= mem_wd;
        if (state_reg == ST_READ)
            rd_reg <= map_mem[cell_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            action_reg <= action;
            col_reg    <= cell_col;
            row_reg    <= cell_row;
            sx_reg     <= sensor_x;
            sy_reg     <= sensor_y;
            yaw_reg    <= sensor_heading;
            score_reg  <= match_score;
        end
        if (state_reg == ST_ROUTE)
        begin
            zero_reg <= zero_vec;
            if (!range_ok)
            begin
                res_conf_reg  <= 16'd0;
                res_val_reg   <= 16'd0;
                res_fused_reg <= 1'b0;
            end
            else
            begin
                res_conf_reg  <= l_conf;
                res_val_reg   <= l_val;
                res_fused_reg <= 1'b0;
            end
        end
        if (state_reg == ST_BEAR)
            mag_reg <= mag_next;
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_CONF)
        begin
            c_reg       <= c_next;
            acc1_reg    <= '0;
            acc2_reg    <= '0;
            mul_cnt_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
            if (mul_cnt_reg == 3'd1 || mul_cnt_reg == 3'd2)
                acc1_reg <= acc1_reg + prod_reg;
            else if (mul_cnt_reg == 3'd3 || mul_cnt_reg == 3'd4)
                acc2_reg <= acc2_reg + prod_reg;
        end
        if (state_reg == ST_W_DIVC && div_done)
            res_conf_reg <= quo_sat;
        if (state_reg == ST_W_DIVV && div_done)
        begin
            res_val_reg   <= quo_sat;
            res_fused_reg <= 1'b1;
        end
        if (out_load)
        begin
            out_conf_reg  <= res_conf_reg;
            out_val_reg   <= res_val_reg;
            out_fused_reg <= res_fused_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cell_confidence = out_conf_reg;
    assign cell_value      = out_val_reg;
    assign fused           = out_fused_reg;

    // accept input only when the sequencer is idle
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == ST_IDLE)
        else $error("input accepted outside idle");

    // memory writes come only from the clearing sweep or the write-back step
    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("unexpected map write");

    // a fused cell always carries a nonzero confidence
    a_fused_conf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fused) |-> cell_confidence != 16'd0)
        else $error("fused cell with zero confidence");

    // after a result is placed in the output register, the sequencer is idle and out_valid is high
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> state_reg == ST_IDLE && out_valid)
        else $error("result load without return to idle");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fov_confidence_value_fusion_top: random and directed
// cell transactions against a cycle-free predictor of the fused confidence/value map.
// Depends on fcvf_pkg and the RTL under src.
module tb_top;
    import fcvf_pkg::*;

    typedef struct {
        bit        action;
        bit [6:0]  col;
        bit [6:0]  row;
        bit [12:0] sx;
        bit [12:0] sy;
        bit [15:0] yaw;
        bit [15:0] score;
    } cell_req_t;

    typedef struct {
        bit [15:0] conf;
        bit [15:0] val;
        bit        fused;
    } cell_result_t;

    // Predicts the stored pair of each cell and queues the result for each transaction.
    class fusion_scoreboard;
        bit [31:0]    arctan [16];
        bit [15:0]    conf_map [CELLS];
        bit [15:0]    value_map [CELLS];
        bit [14:0]    fov;
        cell_result_t pending [$];
        int           errors;
        int           checked;
        int           fuse_count;

        function new();
            arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                       32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                       32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                       32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
            foreach (conf_map[k]) begin
                conf_map[k]  = '0;
                value_map[k] = '0;
            end
            fov        = FOV_RESET;
            errors     = 0;
            checked    = 0;
            fuse_count = 0;
        endfunction

        function bit [15:0] bearing(longint dx, longint dy);
            longint    x;
            longint    y;
            longint    nx;
            bit [31:0] z;
            bit [31:0] t;
            if (dx == 0 && dy == 0)
                return 16'd0;
            x = dx * 256;
            y = dy * 256;
            z = 32'd0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < 16; i++)
            begin
                if (y > 0)
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + arctan[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - arctan[i];
                end
                x = nx;
            end
            t = z + 32'h8000;
            return t[31:16];
        endfunction

        function longint cos_squared(longint phase);
            longint x;
            longint y;
            longint z;
            longint nx;
            longint sq;
            x = 39797;
            y = 0;
            z = phase * 65536;
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(arctan[i]);
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(arctan[i]);
                end
                x = nx;
            end
            if (x < 0)
                x = 0;
            if (x > 65536)
                x = 65536;
            sq = (x * x + 32768) >>> 16;
            return (sq > 65535) ? 65535 : sq;
        endfunction

        function void note_request(cell_req_t r);
            int           adr;
            longint       dx;
            longint       dy;
            bit [15:0]    rel16;
            longint       mag;
            longint       fv;
            longint       p;
            longint       c;
            longint       l;
            longint       lv;
            longint       den;
            longint       q;
            cell_result_t res;
            adr       = int'(r.row) * MAP_SIDE + int'(r.col);
            res.fused = 1'b0;
            if (r.action == 1'b0)
            begin
                dx    = longint'(r.col) * 64 + 32 - longint'(r.sx);
                dy    = longint'(r.row) * 64 + 32 - longint'(r.sy);
                rel16 = bearing(dx, dy) - r.yaw;
                mag   = rel16[15] ? 65536 - longint'(rel16) : longint'(rel16);
                fv    = (fov == 0) ? 1 : longint'(fov);
                p     = ((mag * 65536 + fv) / (2 * fv)) % 32768;
                if (p >= 16384)
                    p = p - 32768;
                c = cos_squared(p);
                if (c != 0)
                begin
                    l   = conf_map[adr];
                    lv  = value_map[adr];
                    den = c + l;
                    q   = (c * c + l * l + den / 2) / den;
                    conf_map[adr] = (q > 65535) ? 16'hFFFF : q[15:0];
                    q   = (c * longint'(r.score) + l * lv + den / 2) / den;
                    value_map[adr] = (q > 65535) ? 16'hFFFF : q[15:0];
                    res.fused = 1'b1;
                    fuse_count++;
                end
            end
            res.conf = conf_map[adr];
            res.val  = value_map[adr];
            pending.push_back(res);
        endfunction

        function void check_result(bit [15:0] conf, bit [15:0] val, bit fsd);
            cell_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: cell_confidence %0d cell_value %0d fused %0d",
                       conf, val, fsd);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (conf !== e.conf)
            begin
                $error("cell_confidence: expected %0d, actual %0d", e.conf, conf);
                errors++;
            end
            if (val !== e.val)
            begin
                $error("cell_value: expected %0d, actual %0d", e.val, val);
                errors++;
            end
            if (fsd !== e.fused)
            begin
                $error("fused: expected %0d, actual %0d", e.fused, fsd);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 60000;   // covers the post-reset map sweep

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [6:0]  cell_col;
    logic [6:0]  cell_row;
    logic [12:0] sensor_x;
    logic [12:0] sensor_y;
    logic [15:0] sensor_heading;
    logic [15:0] match_score;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] cell_confidence;
    logic [15:0] cell_value;
    logic        fused;

    fusion_scoreboard map_sb;
    bit               quiet;        // no idling on either side
    int               idle_pct;     // sender idling chance per transaction
    int               stall_left;
    int               dead_cycles;
    int               sent;

    fov_confidence_value_fusion_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .cell_col        (cell_col),
        .cell_row        (cell_row),
        .sensor_x        (sensor_x),
        .sensor_y        (sensor_y),
        .sensor_heading  (sensor_heading),
        .match_score     (match_score),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cell_confidence (cell_confidence),
        .cell_value      (cell_value),
        .fused           (fused)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog: count cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles > STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then stall in random bursts.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                map_sb.check_result(cell_confidence, cell_value, fused);
            if (quiet)
                stall_left = 0;
            else if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 15);
            out_stall <= (stall_left > 0);
        end
    end

    // Present one transaction and hold it until accepted; maybe idle first.
    task automatic send_cell(cell_req_t r);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action         <= r.action;
        cell_col       <= r.col;
        cell_row       <= r.row;
        sensor_x       <= r.sx;
        sensor_y       <= r.sy;
        sensor_heading <= r.yaw;
        match_score    <= r.score;
        in_valid       <= 1'b1;
        do @(posedge clk); while (in_stall);
        map_sb.note_request(r);
        sent++;
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (map_sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Write the field of view while the block is idle.
    task automatic write_fov(bit [14:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        map_sb.fov = v;
    endtask

    function automatic cell_req_t make_req(bit act, int col, int row, int sx, int sy,
                                           int yaw, int score);
        cell_req_t r;
        r.action = act;
        r.col    = 7'(col);
        r.row    = 7'(row);
        r.sx     = 13'(sx);
        r.sy     = 13'(sy);
        r.yaw    = 16'(yaw);
        r.score  = 16'(score);
        return r;
    endfunction

    // Mostly fuse transactions aimed into the field of view, with hot cells so the
    // stored pair keeps evolving; the rest are reads and unaimed poses.
    function automatic cell_req_t random_req();
        cell_req_t r;
        int        pick;
        int        half;
        longint    ox;
        longint    oy;
        pick     = $urandom_range(0, 99);
        r.score  = 16'($urandom);
        r.action = 1'b0;
        if ($urandom_range(0, 1) == 0)
        begin
            r.col = 7'($urandom_range(60, 63));
            r.row = 7'($urandom_range(10, 11));
        end
        else
        begin
            r.col = 7'($urandom);
            r.row = 7'($urandom);
        end
        if (pick < 12)
        begin
            r.action = 1'b1;
            r.sx     = 13'($urandom);
            r.sy     = 13'($urandom);
            r.yaw    = 16'($urandom);
        end
        else if (pick < 25)
        begin
            r.sx  = 13'($urandom);
            r.sy  = 13'($urandom);
            r.yaw = 16'($urandom);
        end
        else
        begin
            ox   = longint'(r.col) * 64 + 32 + $urandom_range(0, 2560) - 1280;
            oy   = longint'(r.row) * 64 + 32 + $urandom_range(0, 2560) - 1280;
            r.sx = (ox < 0) ? 13'd0 : (ox > 8191) ? 13'h1FFF : ox[12:0];
            r.sy = (oy < 0) ? 13'd0 : (oy > 8191) ? 13'h1FFF : oy[12:0];
            half = (map_sb.fov == 0) ? 1 : int'(map_sb.fov) / 2 + 1;
            r.yaw = 16'(map_sb.bearing(longint'(r.col) * 64 + 32 - longint'(r.sx),
                                       longint'(r.row) * 64 + 32 - longint'(r.sy))
                        + $urandom_range(0, 2 * half) - half);
        end
        return r;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++)
            send_cell(random_req());
    endtask

    initial
    begin
        bit [14:0] fov_plan [5];
        map_sb         = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        action         = 1'b0;
        cell_col       = '0;
        cell_row       = '0;
        sensor_x       = '0;
        sensor_y       = '0;
        sensor_heading = '0;
        match_score    = '0;
        quiet          = 1'b0;
        idle_pct       = 30;
        dead_cycles    = 0;
        sent           = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of empty cells, sensor on a cell centre, grid corners,
        // score and heading extremes, edge of the field of view, and behind it.
        send_cell(make_req(1, 0, 0, 0, 0, 0, 0));
        send_cell(make_req(0, 0, 0, 32, 32, 0, 65535));
        send_cell(make_req(0, 0, 0, 0, 32, 0, 0));
        send_cell(make_req(1, 0, 0, 8191, 8191, 65535, 65535));
        send_cell(make_req(0, 127, 127, 8191, 8191, 40960, 65535));
        send_cell(make_req(0, 127, 127, 8191, 8191, 40960, 65535));
        send_cell(make_req(0, 127, 0, 0, 8191, 65535, 12345));
        send_cell(make_req(0, 0, 127, 8191, 0, 16384, 1));
        send_cell(make_req(0, 64, 64, 4000, 4128, 65536 - 7191, 30000));
        send_cell(make_req(0, 64, 64, 4000, 4128, 7191, 30000));
        send_cell(make_req(0, 64, 64, 4000, 4128, 32768, 50000));
        send_cell(make_req(0, 64, 64, 4000, 4128, 0, 50000));
        send_cell(make_req(1, 64, 64, 0, 0, 0, 0));
        send_cell(make_req(0, 5, 9, 352, 608, 0, 65535));
        send_cell(make_req(1, 127, 127, 0, 0, 0, 0));
        drain_results();   // sender holds off until every result is back

        // Random phases across field-of-view settings, extremes and zero among them.
        fov_plan = '{FOV_RESET, 15'd1, 15'd32767, 15'($urandom_range(2, 32766)), 15'd0};
        foreach (fov_plan[ph])
        begin
            if (ph > 0)
                write_fov(fov_plan[ph]);
            idle_pct = (ph == 2) ? 0 : 30;
            if (ph == 4)
                quiet = 1'b1;
            random_phase(387);
            drain_results();
        end
        write_fov(FOV_RESET);

        repeat (200) @(posedge clk);
        $display("covered %0d transactions (%0d fused) over five field-of-view settings",
                 sent, map_sb.fuse_count);
        $display("with random idling and stalls, results checked: %0d", map_sb.checked);
        if (map_sb.errors == 0 && map_sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
src/fcvf_pkg.sv
src/fcvf_cordic.sv
src/fcvf_div.sv
src/fov_confidence_value_fusion_top.sv
dv/tb_top.sv
